@@ rtl/core/dbm_pkg.sv @@
package dbm_pkg;

	localparam int MaxRefs = 1024;
	localparam int MaxLen = 128;
	localparam int RefW = $clog2(MaxRefs);
	localparam int PosW = $clog2(MaxLen);
	localparam int CntW = RefW + 1;
	localparam int ElemAw = RefW + PosW;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [3:0] time_oct;
		logic [3:0] depth_oct;
		logic [15:0] scope;
	} tag_t;

	typedef struct packed {
		logic start;
		logic [17:0] scope_sum;
		logic [47:0] dsum;
		logic tag_match;
	} score_req_t;

	typedef struct packed {
		logic done;
		logic [31:0] score;
	} score_rsp_t;

endpackage

@@ rtl/core/dbm_ram.sv @@
module dbm_ram #(
	parameter int Width = 16,
	parameter int Depth = 128
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/dbm_score.sv @@
module dbm_score import dbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input score_req_t req,
	output logic busy,
	output score_rsp_t rsp
);
	typedef enum logic [3:0] {
		SC_IDLE = 4'b0001,
		SC_SQRT = 4'b0010,
		SC_DIV = 4'b0100,
		SC_DONE = 4'b1000
	} sc_state_t;

	sc_state_t state_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [32:0] root_q;
	logic [5:0] cnt_q;
	logic [40:0] num_q;
	logic [33:0] den_q;
	logic [41:0] drem_q;
	logic [40:0] quo_q;
	logic tm_q;
	logic done_q;
	logic [31:0] score_q;

	logic [34:0] trial;
	logic [41:0] dshift;

	assign trial = {rem_q[32:0], rad_q[63:62]} - {root_q, 2'b01};
	assign dshift = {drem_q[40:0], num_q[40]};
	assign busy = state_q != SC_IDLE;
	assign rsp = {done_q, score_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						state_q <= SC_SQRT;
					end
				end
				SC_SQRT: begin
					if (cnt_q == 6'd31) begin
						state_q <= SC_DIV;
					end
				end
				SC_DIV: begin
					if (cnt_q == 6'd40) begin
						state_q <= SC_DONE;
					end
				end
				SC_DONE: begin
					done_q <= 1'b1;
					state_q <= SC_IDLE;
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				rad_q <= {req.dsum, 16'd0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
				tm_q <= req.tag_match;
				num_q <= {({2'd0, req.scope_sum} + {1'd0, req.scope_sum, 1'b0}), 21'd0};
				drem_q <= '0;
				quo_q <= '0;
			end
			SC_SQRT: begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (!trial[34]) begin
					rem_q <= trial[33:0];
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], rad_q[63:62]};
					root_q <= {root_q[31:0], 1'b0};
				end
				if (cnt_q == 6'd31) begin
					cnt_q <= '0;
					den_q <= 34'd256 + {1'b0, (!trial[34]) ? {root_q[31:0], 1'b1}
						: {root_q[31:0], 1'b0}};
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			SC_DIV: begin
				num_q <= {num_q[39:0], 1'b0};
				if (dshift >= {8'd0, den_q}) begin
					drem_q <= dshift - {8'd0, den_q};
					quo_q <= {quo_q[39:0], 1'b1};
				end else begin
					drem_q <= dshift;
					quo_q <= {quo_q[39:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			SC_DONE: begin
				score_q <= tm_q ? quo_q[31:0] : 32'd0;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done not a pulse");
	a_done_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(state_q == SC_DONE)) else $error("stray done");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_SQRT |-> !rsp.done) else $error("done while busy");
`endif
endmodule

@@ rtl/core/descriptor_best_match.sv @@
// channel  dir  signals
// in       in   in_valid/in_ready, command element depth_scope depth_octave time_octave last
// out      out  out_valid/out_ready, query_index best_index score
// cfg      in   cfg_valid/cfg_ready, cfg_data (descriptor_length)
// Elements up to the descriptor length are written as they are accepted; a last beat then
// holds the input while the unwritten tail of the descriptor is zeroed. A query's last
// beat scans every reference: distances are accumulated from the element RAM, scored in
// the shared square-root/divide unit, and the scan then advances to the next reference.
// Reset empties the store; no clearing pass. Input stalls while scanning; a finished
// scan holds until the output register is free.
module descriptor_best_match import dbm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [15:0] element,
	input logic [15:0] depth_scope,
	input logic [3:0] depth_octave,
	input logic [3:0] time_octave,
	input logic last,
	output logic out_valid,
	input logic out_ready,
	output logic [15:0] query_index,
	output logic [9:0] best_index,
	output logic [31:0] score,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC = 4'b0010,
		ST_SCORE = 4'b0100,
		ST_NEXT = 4'b1000
	} state_t;

	state_t state_q;
	logic [7:0] len_reg_q;
	logic [PosW:0] len;
	logic [CntW-1:0] ref_cnt_q;
	logic [PosW:0] pos_q;
	logic [1:0] open_q;
	logic [15:0] qcnt_q;
	logic [15:0] qidx_q;
	logic [PosW:0] zero_q;
	logic zfill_q;
	logic [1:0] zcmd_q;
	tag_t qtag_q;
	logic [RefW-1:0] ref_q;
	logic [PosW:0] rd_q;
	logic acc_v_s1;
	logic [47:0] dist_q;
	logic [31:0] best_q;
	logic [RefW-1:0] best_i_q;
	logic first_q;

	logic acc;
	logic [PosW:0] pos_eff;
	logic e_we, q_we;
	logic [ElemAw-1:0] e_waddr, e_raddr;
	logic [PosW-1:0] q_waddr;
	logic [15:0] wdata;
	logic [15:0] e_rdata, q_rdata;
	tag_t t_rdata;
	logic t_we;
	logic [16:0] diff;
	logic [15:0] adiff;
	logic [31:0] sq;
	score_req_t req;
	score_rsp_t rsp;
	logic busy;
	logic full;
	logic last_ref;
	logic out_load;

	assign len = (len_reg_q == 8'd0) ? (PosW+1)'(1)
		: ({1'b0, len_reg_q} > 9'(MaxLen)) ? (PosW+1)'(MaxLen) : (PosW+1)'(len_reg_q);
	assign full = ref_cnt_q == CntW'(MaxRefs);
	assign in_ready = state_q == ST_IDLE && !zfill_q;
	assign cfg_ready = 1'b1;
	assign acc = in_valid && in_ready;
	assign pos_eff = (pos_q != '0 && command != open_q) ? '0 : pos_q;
	assign last_ref = {1'b0, ref_q} + CntW'(1) == ref_cnt_q;
	assign out_load = state_q == ST_NEXT && last_ref && (!out_valid || out_ready);

	always_comb begin
		e_we = 1'b0;
		q_we = 1'b0;
		wdata = element;
		e_waddr = {ref_cnt_q[RefW-1:0], pos_eff[PosW-1:0]};
		q_waddr = pos_eff[PosW-1:0];
		if (zfill_q) begin
			wdata = '0;
			e_waddr = {ref_cnt_q[RefW-1:0] - RefW'(1), zero_q[PosW-1:0]};
			q_waddr = zero_q[PosW-1:0];
			e_we = zcmd_q == CMD_LOAD;
			q_we = zcmd_q == CMD_QUERY;
		end else if (acc && pos_eff < len) begin
			e_we = command == CMD_LOAD && !full;
			q_we = command == CMD_QUERY;
		end
	end
	assign t_we = acc && command == CMD_LOAD && last && !full;
	assign e_raddr = {ref_q, rd_q[PosW-1:0]};

	dbm_ram #(.Width(16), .Depth(MaxRefs*MaxLen)) u_elem (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(wdata), .raddr(e_raddr), .rdata(e_rdata));
	dbm_ram #(.Width(16), .Depth(MaxLen)) u_query (
		.clk, .we(q_we), .waddr(q_waddr), .wdata(wdata), .raddr(rd_q[PosW-1:0]),
		.rdata(q_rdata));
	dbm_ram #(.Width(24), .Depth(MaxRefs)) u_tag (
		.clk, .we(t_we), .waddr(ref_cnt_q[RefW-1:0]),
		.wdata({time_octave, depth_octave, depth_scope}), .raddr(ref_q), .rdata(t_rdata));

	assign diff = {1'b0, q_rdata} - {1'b0, e_rdata};
	assign adiff = diff[16] ? 16'(-diff) : diff[15:0];
	assign sq = {16'd0, adiff} * {16'd0, adiff};

	assign req.start = state_q == ST_SCORE && !busy && !rsp.done;
	assign req.scope_sum = {2'd0, qtag_q.scope} + {2'd0, t_rdata.scope};
	assign req.dsum = dist_q;
	assign req.tag_match = t_rdata.depth_oct == qtag_q.depth_oct
		&& t_rdata.time_oct == qtag_q.time_oct;

	dbm_score u_score (.clk, .arst_n, .req, .busy, .rsp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_reg_q <= 8'd128;
			ref_cnt_q <= '0;
			pos_q <= '0;
			open_q <= CMD_LOAD;
			qcnt_q <= '0;
			qidx_q <= '0;
			zfill_q <= 1'b0;
			zero_q <= '0;
			zcmd_q <= CMD_LOAD;
			out_valid <= 1'b0;
			query_index <= '0;
			best_index <= '0;
			score <= '0;
			acc_v_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_reg_q <= cfg_data;
			end
			acc_v_s1 <= 1'b0;
			out_valid <= out_load || (out_valid && !out_ready);
			if (out_load) begin
				query_index <= qidx_q;
				best_index <= best_i_q;
				score <= best_q;
			end
			if (zfill_q) begin
				zero_q <= zero_q + 1'b1;
				if (zero_q == (PosW+1)'(MaxLen - 1)) begin
					zfill_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && command == CMD_CLEAR) begin
						ref_cnt_q <= '0;
						pos_q <= '0;
					end else if (acc && (command == CMD_LOAD || command == CMD_QUERY)) begin
						open_q <= command;
						if (last) begin
							pos_q <= '0;
							zero_q <= (pos_eff < len) ? pos_eff + 1'b1 : pos_eff;
							zcmd_q <= command;
							zfill_q <= !(command == CMD_LOAD && full)
								&& ((pos_eff < len) ? pos_eff + 1'b1 : pos_eff)
								< (PosW+1)'(MaxLen);
							if (command == CMD_LOAD) begin
								if (!full) ref_cnt_q <= ref_cnt_q + 1'b1;
							end else begin
								qcnt_q <= qcnt_q + 16'd1;
								qidx_q <= qcnt_q;
								if (ref_cnt_q != '0) begin
									state_q <= ST_ACC;
								end
							end
						end else if (pos_eff < len) begin
							pos_q <= pos_eff + 1'b1;
						end else begin
							pos_q <= pos_eff;
						end
					end
				end
				ST_ACC: begin
					if (!zfill_q) begin
						if (rd_q < len) begin
							acc_v_s1 <= 1'b1;
						end else if (!acc_v_s1) begin
							state_q <= ST_SCORE;
						end
					end
				end
				ST_SCORE: begin
					if (rsp.done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (!last_ref) begin
						state_q <= ST_ACC;
					end else if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && command == CMD_QUERY && last) begin
			qtag_q <= {time_octave, depth_octave, depth_scope};
			ref_q <= '0;
			rd_q <= '0;
			dist_q <= '0;
			first_q <= 1'b1;
		end
		if (state_q == ST_ACC && !zfill_q && rd_q < len) begin
			rd_q <= rd_q + 1'b1;
		end
		if (acc_v_s1) begin
			dist_q <= dist_q + {16'd0, sq};
		end
		if (state_q == ST_SCORE && rsp.done) begin
			first_q <= 1'b0;
			if (first_q || rsp.score > best_q) begin
				best_q <= rsp.score;
				best_i_q <= ref_q;
			end
		end
		if (state_q == ST_NEXT && !last_ref) begin
			ref_q <= ref_q + 1'b1;
			rd_q <= '0;
			dist_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_no_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("input during scan");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ref_cnt_q <= CntW'(MaxRefs)) else $error("ref count overflow");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(query_index) && $stable(best_index)
		&& $stable(score)) else $error("result changed while waiting");
`endif
endmodule
